### rtl/core/pidh_pkg.sv
// ---------------------------------------------------------------------------
// pidh_pkg - shared types and constants of the PDM decimator
// Sequencer states, register indexes, multiplier widths and reset values.
// ---------------------------------------------------------------------------
package pidh_pkg;

   // shared multiplier: signed operands, one 16-bit chunk plus a sign bit
   localparam int CHUNK_W = 16;
   localparam int MUL_W   = CHUNK_W + 1;
   localparam int PROD_W  = 2 * MUL_W;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_BITS_PER_SAMPLE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MEAN_WEIGHT     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUTPUT_GAIN     = 2'd2;

   localparam int BPS_W    = 10;
   localparam int WEIGHT_W = 16;
   localparam int GAIN_W   = 8;
   localparam int PCM_W    = 16;

   localparam logic [BPS_W-1:0]    BPS_RESET    = 10'd250;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd6554;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 8'd20;

   localparam logic [PCM_W-1:0] PCM_POS_FULL = 16'h7FFF;
   localparam logic [PCM_W-1:0] PCM_NEG_FULL = 16'h8000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_MEAN,
      ST_HIGH,
      ST_CLAMP,
      ST_GAIN,
      ST_OUT
   } state_type;

endpackage

### rtl/core/pidh_mult.sv
// ---------------------------------------------------------------------------
// pidh_mult - shared signed multiplier
// One registered signed MUL_W x MUL_W product, loaded when enabled.
// ---------------------------------------------------------------------------
module pidh_mult
   import pidh_pkg::*;
(
   input  logic                     clock,
   input  logic                     mul_en,
   input  logic signed [MUL_W-1:0]  mul_a,
   input  logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0] prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

### rtl/core/pdm_integrate_decimate_highpass_core.sv
// ---------------------------------------------------------------------------
// pdm_integrate_decimate_highpass_core - PDM to PCM decimator
// Saturating integrator, decimation, running-mean high-pass and gain.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one PDM bit per word (bit 0 of req_tdata; 0 counts the
//   integrator up, 1 counts it down). Every bits_per_sample words (0 acts
//   as 1) the block updates its running mean, mean += w * (integ - mean),
//   and emits one PCM word on rsp_*: (integ - mean) * gain, saturated to
//   16 bits, with rsp_tuser high when saturation occurred.
//   csr_* writes bits_per_sample (0), mean_weight (1, Q0.16) and
//   output_gain (2); write only while the block is idle.
// Sequencing:
//   A bit that does not close a sample leaves the block ready. A bit that
//   closes a sample keeps req_tready low through the whole sequence: the
//   65-bit weight product is built one 16-bit chunk at a time, over
//   ceil((INTEGRATOR_BITS + MEAN_FRACTION_BITS + 1) / 16) chunks (4 with
//   the defaults), on the single 17x17 multiplier that also applies gain.
// Reset (synchronous): integrator, bit count and mean clear, registers
//   return to 250 / 6554 / 20, the output holds no word.
// Back-pressure: the result sits in an output register; bits keep flowing
//   while it waits, and the sequencer holds in its final step only if the
//   next sample is ready before the previous word has been taken.
// ---------------------------------------------------------------------------
module pdm_integrate_decimate_highpass_core
   import pidh_pkg::*;
#(
   parameter int INTEGRATOR_BITS    = 32,
   parameter int MEAN_FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] pdm_bit, [7:1] ignored
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PCM_W-1:0]      rsp_tdata,   // [15:0] pcm_sample
   output logic                  rsp_tuser,   // [0] clipped
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // mean width, difference width and chunk layout
   localparam int MW     = INTEGRATOR_BITS + MEAN_FRACTION_BITS;
   localparam int DW     = MW + 1;
   localparam int NCHUNK = (DW + CHUNK_W - 1) / CHUNK_W;
   localparam int AW     = NCHUNK * CHUNK_W;
   localparam int AWX    = AW + PROD_W;
   localparam int CW     = $clog2(NCHUNK);

   localparam logic signed [INTEGRATOR_BITS-1:0] INT_MAX =
      {1'b0, {(INTEGRATOR_BITS-1){1'b1}}};
   localparam logic signed [INTEGRATOR_BITS-1:0] INT_MIN =
      {1'b1, {(INTEGRATOR_BITS-1){1'b0}}};
   localparam logic signed [DW-1:0] ROUND_BIAS = DW'((2**MEAN_FRACTION_BITS) - 1);
   localparam logic signed [DW-1:0] HIGH_MAX   = DW'((2**(MUL_W-1)) - 1);
   localparam logic signed [DW-1:0] HIGH_MIN   = DW'(-(2**(MUL_W-1)));
   localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32767);
   localparam logic signed [PROD_W-1:0] SAT_MIN = PROD_W'(-32768);

   // configuration registers
   logic [BPS_W-1:0]    bps_ff, bps_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;

   // state and datapath
   state_type                   state_ff, state_in;
   logic signed [INTEGRATOR_BITS-1:0] integ_ff, integ_in;
   logic [BPS_W-1:0]            count_ff, count_in;
   logic signed [MW-1:0]        mean_ff, mean_in;
   logic signed [DW-1:0]        diff_ff, diff_in;
   logic signed [AW-1:0]        acc_ff, acc_in;
   logic [CW-1:0]               chunk_ff, chunk_in;
   logic signed [MUL_W-1:0]     high_ff, high_in;

   // output register
   logic                        out_valid_ff, out_valid_in;
   logic [PCM_W-1:0]            out_data_ff, out_data_in;
   logic                        out_clip_ff, out_clip_in;

   // shared multiplier
   logic                        mul_en;
   logic signed [MUL_W-1:0]     mul_a, mul_b;
   logic signed [PROD_W-1:0]    prod_ff;

   // helpers
   logic                        accept;
   logic                        sample_now;
   logic [BPS_W-1:0]            count_next, ratio;
   logic signed [DW-1:0]        integ_scaled;
   logic signed [AW-1:0]        diff_ext;
   logic [CHUNK_W-1:0]          chunk_bits;
   logic signed [AWX-1:0]       prod_ext;
   logic signed [DW-1:0]        rounded, high_full;

   pidh_mult u_mult (
      .clock   (clock),
      .mul_en  (mul_en),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_clip_ff;

   // decimation count
   assign ratio      = (bps_ff == '0) ? BPS_W'(1) : bps_ff;
   assign count_next = count_ff + BPS_W'(1);
   assign sample_now = (count_next >= ratio);

   assign integ_scaled = DW'(integ_ff) <<< MEAN_FRACTION_BITS;
   assign diff_ext     = AW'(diff_ff);
   assign chunk_bits   = diff_ext[chunk_ff*CHUNK_W +: CHUNK_W];
   assign prod_ext     = AWX'(prod_ff);
   assign rounded      = diff_ff + (diff_ff[DW-1] ? ROUND_BIAS : '0);
   assign high_full    = rounded >>> MEAN_FRACTION_BITS;

   // configuration writes
   always_comb begin
      bps_in    = bps_ff;
      weight_in = weight_ff;
      gain_in   = gain_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_BITS_PER_SAMPLE: bps_in    = csr_wdata[BPS_W-1:0];
            CSR_MEAN_WEIGHT:     weight_in = csr_wdata[WEIGHT_W-1:0];
            CSR_OUTPUT_GAIN:     gain_in   = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      integ_in     = integ_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      chunk_in     = chunk_ff;
      high_in      = high_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_clip_in  = out_clip_ff;
      mul_en       = 1'b0;
      mul_a        = {1'b0, weight_ff};
      mul_b        = {1'b0, chunk_bits};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // count up on 0, down on 1, hold at the limits
               if (!req_tdata[0]) begin
                  if (integ_ff != INT_MAX) integ_in = integ_ff + INTEGRATOR_BITS'(1);
               end else begin
                  if (integ_ff != INT_MIN) integ_in = integ_ff - INTEGRATOR_BITS'(1);
               end
               if (sample_now) begin
                  count_in = '0;
                  state_in = ST_DIFF;
               end else begin
                  count_in = count_next;
               end
            end
         end
         ST_DIFF: begin
            diff_in  = integ_scaled - DW'(mean_ff);
            acc_in   = '0;
            chunk_in = CW'(NCHUNK - 1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // top chunk carries the sign, lower chunks are unsigned
            mul_en = 1'b1;
            if (chunk_ff == CW'(NCHUNK - 1)) mul_b = {chunk_bits[CHUNK_W-1], chunk_bits};
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (chunk_ff == '0) begin
               // lowest chunk: only its carry into bit 16 survives the floor
               acc_in   = acc_ff + AW'(prod_ff[PROD_W-1:CHUNK_W]);
               state_in = ST_MEAN;
            end else begin
               acc_in   = (acc_ff <<< CHUNK_W) + prod_ext[AW-1:0];
               chunk_in = chunk_ff - CW'(1);
               state_in = ST_MUL;
            end
         end
         ST_MEAN: begin
            mean_in  = mean_ff + acc_ff[MW-1:0];
            state_in = ST_HIGH;
         end
         ST_HIGH: begin
            diff_in  = integ_scaled - DW'(mean_ff);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            // clamp to 17 bits: keeps sign and saturation for any gain
            if (high_full > HIGH_MAX)      high_in = HIGH_MAX[MUL_W-1:0];
            else if (high_full < HIGH_MIN) high_in = HIGH_MIN[MUL_W-1:0];
            else                           high_in = high_full[MUL_W-1:0];
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            mul_en   = 1'b1;
            mul_a    = high_ff;
            mul_b    = {{(MUL_W-GAIN_W){1'b0}}, gain_ff};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               if (prod_ff > SAT_MAX) begin
                  out_data_in = PCM_POS_FULL;
                  out_clip_in = 1'b1;
               end else if (prod_ff < SAT_MIN) begin
                  out_data_in = PCM_NEG_FULL;
                  out_clip_in = 1'b1;
               end else begin
                  out_data_in = prod_ff[PCM_W-1:0];
                  out_clip_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff       <= BPS_RESET;
         weight_ff    <= WEIGHT_RESET;
         gain_ff      <= GAIN_RESET;
         state_ff     <= ST_IDLE;
         integ_ff     <= '0;
         count_ff     <= '0;
         mean_ff      <= '0;
         chunk_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         bps_ff       <= bps_in;
         weight_ff    <= weight_in;
         gain_ff      <= gain_in;
         state_ff     <= state_in;
         integ_ff     <= integ_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         chunk_ff     <= chunk_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      acc_ff      <= acc_in;
      high_ff     <= high_in;
      out_data_ff <= out_data_in;
      out_clip_ff <= out_clip_in;
   end

   // a new result word only appears out of the final step
   a_word_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result word raised outside the output step");

   // a bit that does not close a sample leaves the block ready
   a_plain_bit_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && !sample_now) |=> (state_ff == ST_IDLE))
      else $error("non-sampling bit left the idle state");

   // clip flag only with a full-scale word
   a_clip_full_scale: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_clip_ff) |->
      (out_data_ff == PCM_POS_FULL || out_data_ff == PCM_NEG_FULL))
      else $error("clip flag on a sample below full scale");

   // a waiting word is not overwritten by the next sample
   a_word_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("pending result word lost");

endmodule

### tb/tb_pdm_integrate_decimate_highpass_core.sv
// ---------------------------------------------------------------------------
// tb_pdm_integrate_decimate_highpass_core - self-checking bench of the decimator
// Streams PDM bits through the core under random sender bursts and receiver
// stalls, predicts each PCM word from a bit-exact integrator / running-mean
// model, and compares every returned word field by field in order.
// ---------------------------------------------------------------------------
module tb_pdm_integrate_decimate_highpass_core;
   import pidh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // A 16-bit integrator runs the chunked mean update at a width other
   // than the default; the mean keeps its full 16 fraction bits.
   localparam int     INTEG_W    = 16;
   localparam int     FRAC_W     = 16;
   localparam longint INTEG_MAX  = (longint'(1) << (INTEG_W - 1)) - 1;
   localparam longint INTEG_MIN  = -(longint'(1) << (INTEG_W - 1));
   localparam longint MEAN_ONE   = longint'(1) << FRAC_W;
   localparam longint PCM_MAX    = 32767;
   localparam longint PCM_MIN    = -32768;

   // index that decodes to no register; a write there must change nothing
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   // a closing bit holds the core busy through its whole sequence;
   // allow well over that before touching the registers
   localparam int DRAIN_GAP   = 32;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_BITS  = 183;
   localparam int TIMEOUT_NS  = 5_000_000;

   typedef struct packed {
      logic [PCM_W-1:0] pcm;
      logic             clip;
   } pcm_word_type;

   typedef enum logic [1:0] {SEG_NOISE, SEG_RUN, SEG_TOGGLE, SEG_DENSITY} seg_shape_type;
   typedef enum logic [1:0] {
      STALL_NONE, STALL_RANDOM, STALL_SPARSE, STALL_SQUARE
   } stall_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;   // [0] pdm_bit, [7:1] ignored
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PCM_W-1:0]      rsp_tdata;         // [15:0] pcm_sample
   logic                  rsp_tuser;         // [0] clipped
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // bits waiting for the driver, PCM words waiting for the core
   logic [7:0]   pdm_queue[$];
   pcm_word_type pcm_expected[$];
   int           bits_queued = 0;
   int           bits_taken  = 0;
   int           fail_count  = 0;

   // decimator state and register copies, as the core should hold them
   longint            integ   = 0;
   longint            mean    = 0;
   logic [BPS_W-1:0]  bit_cnt = '0;
   logic [BPS_W-1:0]  cfg_bps    = BPS_RESET;
   logic [WEIGHT_W-1:0] cfg_weight = WEIGHT_RESET;
   logic [GAIN_W-1:0] cfg_gain   = GAIN_RESET;

   // sender and receiver pacing
   int             burst_left  = 0;
   int             gap_left    = 0;
   int             stall_cycle = 0;
   stall_mode_type stall_mode  = STALL_NONE;

   pdm_integrate_decimate_highpass_core #(
      .INTEGRATOR_BITS    (INTEG_W),
      .MEAN_FRACTION_BITS (FRAC_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the integrator by one PDM bit and, at a decimation point,
   // update the mean and queue the PCM word the core must return.
   function automatic void take_pdm_bit(input logic pdm);
      longint              diff;
      longint              high;
      longint              scaled;
      longint              gain_l;
      logic signed [95:0]  diff_wide;
      logic signed [95:0]  weight_wide;
      logic signed [95:0]  prod;
      logic [BPS_W-1:0]    ratio;
      pcm_word_type        word;

      // saturate rather than wrap
      if (!pdm) begin
         if (integ < INTEG_MAX) integ++;
      end else if (integ > INTEG_MIN) begin
         integ--;
      end

      // a ratio of zero behaves as one; a ratio lowered below the running
      // count fires on the very next bit
      ratio = cfg_bps;
      if (ratio == '0) ratio = BPS_W'(1);
      bit_cnt = bit_cnt + 1'b1;
      if (bit_cnt < ratio) return;
      bit_cnt = '0;

      // exact floor(weight * diff / 2^16), kept wide enough never to overflow
      diff        = integ * MEAN_ONE - mean;
      diff_wide   = diff;
      weight_wide = {80'd0, cfg_weight};
      prod        = diff_wide * weight_wide;
      mean        = mean + longint'(prod >>> WEIGHT_W);

      // high-pass value, truncated toward zero, then gain and clamp
      diff   = integ * MEAN_ONE - mean;
      high   = (diff >= 0) ? (diff >>> FRAC_W) : -((-diff) >>> FRAC_W);
      gain_l = cfg_gain;
      scaled = high * gain_l;
      word.clip = 1'b0;
      if (scaled > PCM_MAX) begin
         scaled    = PCM_MAX;
         word.clip = 1'b1;
      end else if (scaled < PCM_MIN) begin
         scaled    = PCM_MIN;
         word.clip = 1'b1;
      end
      word.pcm = scaled[PCM_W-1:0];
      pcm_expected.push_back(word);
   endfunction

   // Queue one bit for the driver with random junk above bit 0.
   function automatic void queue_bit(input logic pdm);
      pdm_queue.push_back({7'($urandom_range(0, 127)), pdm});
      bits_queued++;
   endfunction

   // One register write: strobe for a single edge, then mirror it.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BITS_PER_SAMPLE: cfg_bps    = value[BPS_W-1:0];
         CSR_MEAN_WEIGHT:     cfg_weight = value[WEIGHT_W-1:0];
         CSR_OUTPUT_GAIN:     cfg_gain   = value[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   // Write all three registers; pad the narrow ones with random upper bits,
   // which the core must drop.
   task automatic set_config(input logic [BPS_W-1:0] bps,
                             input logic [WEIGHT_W-1:0] weight,
                             input logic [GAIN_W-1:0] gain);
      write_csr(CSR_BITS_PER_SAMPLE,
                {6'($urandom_range(0, 63)), bps});
      write_csr(CSR_MEAN_WEIGHT, weight);
      write_csr(CSR_OUTPUT_GAIN,
                {8'($urandom_range(0, 255)), gain});
   endtask

   // Hold until every queued bit is taken and every PCM word has come back,
   // then let a closing bit that produced nothing run out.
   task automatic drain();
      do @(posedge clock);
      while (bits_taken != bits_queued || pcm_expected.size() != 0);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   // Sender: bursts of random length, random gaps, some bursts back to back.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pdm_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pdm_queue.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 47);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stall patterns, switched on a stall_cycle counter.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_cycle = 0;
         stall_mode  = STALL_NONE;
      end else begin
         stall_cycle++;
         if (stall_cycle % 256 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            STALL_NONE:   rsp_tready <= 1'b1;
            STALL_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
            STALL_SPARSE: rsp_tready <= (stall_cycle % 32 == 0);
            default:      rsp_tready <= stall_cycle[3];
         endcase
      end
   end

   // Monitor: check the returned word first, then predict from the taken bit,
   // so a word landing on the same edge is matched against older bits only.
   always @(posedge clock) begin
      pcm_word_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pcm_expected.size() == 0) begin
               $display("%0t: unexpected PCM word: expected none, actual %0d clip %0b",
                        $time, $signed(rsp_tdata), rsp_tuser);
               fail_count++;
            end else begin
               want = pcm_expected.pop_front();
               if (rsp_tdata !== want.pcm) begin
                  $display("%0t: pcm_sample mismatch: expected %0d, actual %0d",
                           $time, $signed(want.pcm), $signed(rsp_tdata));
                  fail_count++;
               end
               if (rsp_tuser !== want.clip) begin
                  $display("%0t: clipped mismatch: expected %0b, actual %0b",
                           $time, want.clip, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            take_pdm_bit(req_tdata[0]);
            bits_taken++;
         end
      end
   end

   // Stimulus
   initial begin
      int            n_bits;
      int            seg_len;
      int            density;
      seg_shape_type seg_shape;
      logic          seg_bit;
      logic          pdm;
      logic [BPS_W-1:0]    bps;
      logic [WEIGHT_W-1:0] weight;
      logic [GAIN_W-1:0]   gain;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one sample per bit, mean frozen, full gain: the scaled integrator
      // itself, with the top tdata bits set on some words
      set_config(10'd1, 16'd0, 8'd255);
      write_csr(CSR_UNUSED, 16'($urandom));
      pdm_queue.push_back(8'h00);
      pdm_queue.push_back(8'hFE);
      pdm_queue.push_back(8'h01);
      pdm_queue.push_back(8'hFF);
      pdm_queue.push_back(8'h81);
      pdm_queue.push_back(8'h7E);
      bits_queued += 6;
      drain();

      // zero ratio acts as one; full-scale weight pulls the mean right in
      set_config(10'd0, 16'hFFFF, 8'd1);
      repeat (4) queue_bit(1'b0);
      drain();

      // stop mid-sample, then drop the ratio below the count taken so far
      set_config(10'd10, WEIGHT_RESET, GAIN_RESET);
      repeat (5) queue_bit(1'b1);
      drain();
      write_csr(CSR_BITS_PER_SAMPLE, 16'd3);
      queue_bit(1'b1);
      queue_bit(1'b0);
      drain();

      // zero gain gives silence
      set_config(10'd2, 16'd30000, 8'd0);
      repeat (4) queue_bit(1'($urandom_range(0, 1)));
      drain();

      // random phases: each picks a setting, streams shaped bit patterns,
      // then drains fully before the next setting goes in
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(0, 6))
            0:       bps = 10'd0;
            1:       bps = 10'd1;
            2:       bps = 10'd1023;
            3:       bps = BPS_RESET;
            default: bps = 10'($urandom_range(2, 40));
         endcase
         case ($urandom_range(0, 4))
            0:       weight = 16'd0;
            1:       weight = 16'hFFFF;
            2:       weight = WEIGHT_RESET;
            default: weight = 16'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0:       gain = 8'd0;
            1:       gain = 8'd255;
            2:       gain = GAIN_RESET;
            default: gain = 8'($urandom_range(1, 255));
         endcase
         set_config(bps, weight, gain);

         n_bits = 0;
         while (n_bits < PHASE_BITS) begin
            seg_len   = $urandom_range(1, 60);
            seg_shape = seg_shape_type'($urandom_range(0, 3));
            seg_bit   = 1'($urandom_range(0, 1));
            density   = $urandom_range(0, 16);
            for (int k = 0; k < seg_len; k++) begin
               case (seg_shape)
                  SEG_NOISE:  pdm = 1'($urandom_range(0, 1));
                  SEG_RUN:    pdm = seg_bit;
                  SEG_TOGGLE: pdm = seg_bit ^ k[0];
                  default:    pdm = ($urandom_range(0, 15) < density);
               endcase
               queue_bit(pdm);
            end
            n_bits += seg_len;
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("pdm_integrate_decimate_highpass_core test passed");
      end else begin
         $display("pdm_integrate_decimate_highpass_core test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of every bit and every stall.
   initial begin
      #(TIMEOUT_NS);
      $display("pdm_integrate_decimate_highpass_core test failed");
      $finish;
   end

endmodule

### pdm_integrate_decimate_highpass_core.f
rtl/core/pidh_pkg.sv
rtl/core/pidh_mult.sv
rtl/core/pdm_integrate_decimate_highpass_core.sv
tb/tb_pdm_integrate_decimate_highpass_core.sv
